>>> rtl/gcd_pkg.sv
package gcd_pkg;

  // Angle word: degrees, 24 fraction bits, room for a full turn
  localparam int unsigned ANG_W = 34;
  // CORDIC x/y word: Q30 with headroom for the vectoring gain
  localparam int unsigned XY_W = 34;
  // Square root working width
  localparam int unsigned SQ_W = 63;
  localparam int unsigned SQRT_STEPS = 32;

  localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd6039797760;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd3019898880;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1509949440;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic [13:0] EARTH_DIAM_KM = 14'd12742;
  localparam logic [22:0] DIST_MAX = 23'h7F_FFFF;

  localparam longint unsigned DEG_PER_RAD_Q24 = 64'd961263669;
  localparam longint unsigned ATAN_TAB [11] = '{
    64'd754974720, 64'd445687602, 64'd235489088, 64'd119537938, 64'd60000934,
    64'd30029717, 64'd15018523, 64'd7509720, 64'd3754917, 64'd1877466, 64'd938734
  };

  // atan(2^-i) in Q24 degrees
  function automatic logic signed [ANG_W-1:0] stage_angle(input int unsigned i);
    longint unsigned v;
    if (i < 11) begin
      v = ATAN_TAB[i];
    end else begin
      v = (DEG_PER_RAD_Q24 + (64'd1 << (i - 1))) >> i;
    end
    return ANG_W'(v);
  endfunction

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sq_t;

  // One digit of the restoring integer square root
  function automatic sq_t sqrt_step(input sq_t s, input logic [SQ_W-1:0] b);
    sq_t r;
    logic [SQ_W-1:0] t;
    t = s.res + b;
    if (s.rem >= t) begin
      r.rem = s.rem - t;
      r.res = (s.res >> 1) + b;
    end else begin
      r.rem = s.rem;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

endpackage

>>> rtl/great_circle_distance.sv
// Haversine great-circle distance on a 6371 km sphere. Each input transfer
// carries two points (latitude/longitude in degrees, 16 fraction bits); each
// output transfer carries the distance in km with 8 fraction bits and a flag
// that is set when it is strictly below max_distance. One pair is accepted
// per clock while the skid entry is empty. The pipeline runs through two
// angle-reduction stages, the rotation CORDIC (one stage per iteration), four
// multiply stages, a 32-stage square root, the vectoring CORDIC and two
// scaling stages, then the output register. A two-entry output buffer lets
// the pipeline keep moving after the sink stalls until a result waits in the
// skid entry; after that the whole pipeline holds.
module great_circle_distance import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
  input  logic [103:0]  s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // distance_km[22:0], within_range[23]
  output logic [23:0]   m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_we_i,
  input  logic [22:0]   cfg_wdata_i
);

  localparam int unsigned LAT = 2 * CORDIC_STAGES + 40;
  localparam int unsigned M4_IDX = CORDIC_STAGES + 5;
  localparam int unsigned SQ_IDX = M4_IDX + SQRT_STEPS;

  logic        en;
  logic [22:0] max_distance_q;
  logic        v_q [LAT];

  // Search radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_distance_q <= '0;
    end else if (cfg_we_i) begin
      max_distance_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < LAT; k++) v_q[k] <= v_q[k-1];
    end
  end

  assign s_axis_tready = en;

  // Input angles in Q24 degrees: half differences and the two latitudes
  logic signed [23:0] lat_a, lat_b;
  logic signed [24:0] lon_a, lon_b;
  logic signed [24:0] dlat;
  logic signed [25:0] dlon;
  logic signed [ANG_W-1:0] ang_in [4];

  assign lat_a = s_axis_tdata[23:0];
  assign lon_a = s_axis_tdata[48:24];
  assign lat_b = s_axis_tdata[72:49];
  assign lon_b = s_axis_tdata[97:73];
  assign dlat  = {lat_b[23], lat_b} - {lat_a[23], lat_a};
  assign dlon  = {lon_b[24], lon_b} - {lon_a[24], lon_a};
  assign ang_in[0] = {{2{dlat[24]}}, dlat, 7'b0};
  assign ang_in[1] = {dlon[25], dlon, 7'b0};
  assign ang_in[2] = {{2{lat_a[23]}}, lat_a, 8'b0};
  assign ang_in[3] = {{2{lat_b[23]}}, lat_b, 8'b0};

  logic signed [ANG_W-1:0] red_q [4];
  logic signed [ANG_W-1:0] fold_q [4];
  logic                    fneg_q [4];
  logic signed [XY_W-1:0]  sin_c [4];
  logic signed [XY_W-1:0]  cos_c [4];
  logic                    neg_c [4];

  for (genvar u = 0; u < 4; u++) begin : g_unit
    // Wrap into [-180, 180)
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (ang_in[u] >= HALF_TURN) begin
          red_q[u] <= ang_in[u] - FULL_TURN;
        end else if (ang_in[u] < -HALF_TURN) begin
          red_q[u] <= ang_in[u] + FULL_TURN;
        end else begin
          red_q[u] <= ang_in[u];
        end
      end
    end

    // Fold into [-90, 90], cosine sign flips
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (red_q[u] > QUARTER_TURN) begin
          fold_q[u] <= HALF_TURN - red_q[u];
          fneg_q[u] <= 1'b1;
        end else if (red_q[u] < -QUARTER_TURN) begin
          fold_q[u] <= -HALF_TURN - red_q[u];
          fneg_q[u] <= 1'b1;
        end else begin
          fold_q[u] <= red_q[u];
          fneg_q[u] <= 1'b0;
        end
      end
    end

    gcd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot (
      .clk_i (clk_i),
      .en_i  (en),
      .ang_i (fold_q[u]),
      .neg_i (fneg_q[u]),
      .sin_o (sin_c[u]),
      .cos_o (cos_c[u]),
      .neg_o (neg_c[u])
    );
  end

  // M1: squared half-difference sines, signed cosines
  logic signed [31:0] s_lat, s_lon, c_a, c_b;
  logic signed [63:0] sq_lat, sq_lon;
  logic [31:0]        s1sq_q, s2sq_q, s1sq2_q, s1sq3_q;
  logic signed [31:0] ca_q, cb_q, cb2_q;

  assign s_lat  = sin_c[0][31:0];
  assign s_lon  = sin_c[1][31:0];
  assign c_a    = cos_c[2][31:0];
  assign c_b    = cos_c[3][31:0];
  assign sq_lat = s_lat * s_lat;
  assign sq_lon = s_lon * s_lon;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1sq_q <= sq_lat[61:30];
      s2sq_q <= sq_lon[61:30];
      ca_q   <= neg_c[2] ? -c_a : c_a;
      cb_q   <= neg_c[3] ? -c_b : c_b;
    end
  end

  // M2, M3: times cos(lat_a), then cos(lat_b), floor each
  logic signed [32:0] s2sq_s, term1_q, term_q;
  logic signed [64:0] prod1, prod2;

  assign s2sq_s = {1'b0, s2sq_q};
  assign prod1  = s2sq_s * ca_q;
  assign prod2  = term1_q * cb2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      term1_q <= prod1[62:30];
      cb2_q   <= cb_q;
      s1sq2_q <= s1sq_q;
      term_q  <= prod2[62:30];
      s1sq3_q <= s1sq2_q;
    end
  end

  // M4: a, saturated to [0, 1]
  logic signed [33:0] a_sum;
  logic [30:0]        a_q;

  assign a_sum = $signed({2'b0, s1sq3_q}) + {term_q[32], term_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > $signed({3'b0, Q30_ONE})) begin
        a_q <= Q30_ONE;
      end else begin
        a_q <= a_sum[30:0];
      end
    end
  end

  // sqrt(a) and sqrt(1-a), one result bit per stage
  sq_t sy_q [SQRT_STEPS];
  sq_t sx_q [SQRT_STEPS];
  sq_t sy0, sx0;

  assign sy0.rem = {2'b0, a_q, 30'b0};
  assign sy0.res = '0;
  assign sx0.rem = {2'b0, Q30_ONE - a_q, 30'b0};
  assign sx0.res = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] B = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 1 - 2 * k);
    sq_t yi, xi;
    if (k == 0) begin : g_first
      assign yi = sy0;
      assign xi = sx0;
    end else begin : g_next
      assign yi = sy_q[k-1];
      assign xi = sx_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sy_q[k] <= sqrt_step(yi, B);
        sx_q[k] <= sqrt_step(xi, B);
      end
    end
  end

  // Vectoring CORDIC: atan2(sqrt(a), sqrt(1-a)) in Q24 degrees
  logic signed [XY_W-1:0]  vx_q [CORDIC_STAGES];
  logic signed [XY_W-1:0]  vy_q [CORDIC_STAGES];
  logic signed [ANG_W-1:0] vz_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic signed [ANG_W-1:0] T = stage_angle(i);
    logic signed [XY_W-1:0]  xi, yi;
    logic signed [ANG_W-1:0] zi;
    if (i == 0) begin : g_first
      assign xi = {2'b0, sx_q[SQRT_STEPS-1].res[31:0]};
      assign yi = {2'b0, sy_q[SQRT_STEPS-1].res[31:0]};
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_q[i-1];
      assign yi = vy_q[i-1];
      assign zi = vz_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (yi >= 0) begin
          vx_q[i] <= xi + (yi >>> i);
          vy_q[i] <= yi - (xi >>> i);
          vz_q[i] <= zi + T;
        end else begin
          vx_q[i] <= xi - (yi >>> i);
          vy_q[i] <= yi + (xi >>> i);
          vz_q[i] <= zi - T;
        end
      end
    end
  end

  // D1: clamp and convert to Q24 radians, rounded
  logic signed [ANG_W-1:0] z_end;
  logic [31:0]             z_pos;
  logic [58:0]             rad_prod;
  logic [59:0]             rad_sum;
  logic [27:0]             rad_q;

  assign z_end    = vz_q[CORDIC_STAGES-1];
  assign z_pos    = z_end[ANG_W-1] ? '0 : z_end[31:0];
  assign rad_prod = z_pos * DEG2RAD_Q32;
  assign rad_sum  = {1'b0, rad_prod} + 60'h0_8000_0000;

  always_ff @(posedge clk_i) begin
    if (en) rad_q <= rad_sum[59:32];
  end

  // D2: scale by the diameter, round, saturate
  logic [41:0] d_prod;
  logic [42:0] d_sum;
  logic [26:0] d_km;
  logic [22:0] dist_q;

  assign d_prod = rad_q * EARTH_DIAM_KM;
  assign d_sum  = {1'b0, d_prod} + 43'h8000;
  assign d_km   = d_sum[42:16];

  always_ff @(posedge clk_i) begin
    if (en) dist_q <= (d_km > {4'b0, DIST_MAX}) ? DIST_MAX : d_km[22:0];
  end

  // Output register plus skid entry
  logic        inc_valid, inc_within;
  logic        out_valid_q, skid_valid_q;
  logic [22:0] out_dist_q, skid_dist_q;
  logic        out_within_q, skid_within_q;
  logic        out_free;

  assign en         = !skid_valid_q;
  assign inc_valid  = v_q[LAT-1] && en;
  assign inc_within = dist_q < max_distance_q;
  assign out_free   = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= inc_valid;
      end
    end else if (inc_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_dist_q   <= skid_dist_q;
        out_within_q <= skid_within_q;
      end else begin
        out_dist_q   <= dist_q;
        out_within_q <= inc_within;
      end
    end else if (inc_valid) begin
      skid_dist_q   <= dist_q;
      skid_within_q <= inc_within;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_within_q, out_dist_q};

  // The skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // A held skid entry is not dropped while the sink stalls
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("skid entry lost under stall");

  // Saturated a never exceeds one, so the roots stay in range
  a_a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[M4_IDX] |-> (a_q <= Q30_ONE))
    else $error("a out of range");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SQ_IDX] |-> (sy_q[SQRT_STEPS-1].res <= {32'b0, Q30_ONE}))
    else $error("square root out of range");

endmodule

>>> rtl/gcd_rot_cordic.sv
module gcd_rot_cordic import gcd_pkg::*; #(
  parameter int unsigned STAGES = 20
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ANG_W-1:0] ang_i,
  input  logic                    neg_i,
  output logic signed [XY_W-1:0]  sin_o,
  output logic signed [XY_W-1:0]  cos_o,
  output logic                    neg_o
);

  logic signed [XY_W-1:0]  x_q [STAGES];
  logic signed [XY_W-1:0]  y_q [STAGES];
  logic signed [ANG_W-1:0] z_q [STAGES];
  logic                    n_q [STAGES];

  // One micro-rotation per register stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stg
    localparam logic signed [ANG_W-1:0] T = stage_angle(i);
    logic signed [XY_W-1:0]  xi, yi;
    logic signed [ANG_W-1:0] zi;
    logic                    ni;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = ang_i;
      assign ni = neg_i;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign ni = n_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (zi >= 0) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - T;
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + T;
        end
        n_q[i] <= ni;
      end
    end
  end

  assign sin_o = y_q[STAGES-1];
  assign cos_o = x_q[STAGES-1];
  assign neg_o = n_q[STAGES-1];

endmodule

>>> test/great_circle_distance_tb.sv
`timescale 1ns / 100ps

module great_circle_distance_tb;

  localparam int unsigned STAGES = 20;
  localparam int unsigned LATENCY = 2 * STAGES + 41;
  localparam longint LAT_SPAN = 64'sd5898240;
  localparam longint LON_SPAN = 64'sd11796480;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint TURN = 64'sd360 << 24;
  localparam longint HALF = 64'sd180 << 24;
  localparam longint QUARTER = 64'sd90 << 24;
  localparam longint GAIN = 64'sd652032874;
  localparam longint DEG_RAD = 64'sd961263669;
  localparam longint TO_RAD = 64'sd74961321;
  localparam longint DMAX = 64'sd8388607;

  // same bit order as m_axis_tdata: flag on top, distance below
  typedef struct packed {
    logic        near;
    logic [22:0] km;
  } leg_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // distance_km[22:0], within_range[23]
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [22:0]  cfg_wdata_i = '0;

  great_circle_distance #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  leg_t        legs_q[$];
  logic [22:0] radius_km = '0;
  int          send_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_cycles = 0;
  int          mismatches = 0;
  int          legs_seen = 0;
  int          pairs_sent = 0;
  int          near_hits = 0;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint tab[11] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                        30029717, 15018523, 7509720, 3754917, 1877466, 938734};
    if (i < 11) begin
      return tab[i];
    end
    return (DEG_RAD + (64'sd1 << (i - 1))) >>> i;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  // rotation CORDIC in Q24 degrees, quadrant folded
  task automatic rotate(input longint ang, output longint s, output longint c);
    longint r, x, y, xn;
    bit flip;
    r = ang % TURN;
    x = GAIN;
    y = 0;
    flip = 0;
    if (r < 0) r += TURN;
    if (r >= HALF) r -= TURN;
    if (r > QUARTER) begin
      r = HALF - r;
      flip = 1;
    end else if (r < -QUARTER) begin
      r = -HALF - r;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (r >= 0) begin
        xn = x - fshr(y, i);
        y = y + fshr(x, i);
        r -= atan_step(i);
      end else begin
        xn = x + fshr(y, i);
        y = y - fshr(x, i);
        r += atan_step(i);
      end
      x = xn;
    end
    s = y;
    c = flip ? -x : x;
  endtask

  function automatic longint arc_angle(longint x, longint y);
    longint z, xn;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (y >= 0) begin
        xn = x + fshr(y, i);
        y = y - fshr(x, i);
        z += atan_step(i);
      end else begin
        xn = x - fshr(y, i);
        y = y + fshr(x, i);
        z -= atan_step(i);
      end
      x = xn;
    end
    return z < 0 ? 0 : z;
  endfunction

  task automatic haversine(input logic [103:0] pair, output leg_t leg);
    longint la, oa, lb, ob, s1, c1, s2, c2, sa, ca, sb, cb;
    longint h, term, a, z, rad, d;
    la = longint'($signed(pair[23:0]));
    oa = longint'($signed(pair[48:24]));
    lb = longint'($signed(pair[72:49]));
    ob = longint'($signed(pair[97:73]));
    rotate((lb - la) * 128, s1, c1);
    rotate((ob - oa) * 128, s2, c2);
    rotate(la * 256, sa, ca);
    rotate(lb * 256, sb, cb);
    h = (s1 * s1) >>> 30;
    term = fshr(((s2 * s2) >>> 30) * ca, 30);
    term = fshr(term * cb, 30);
    a = h + term;
    if (a < 0) a = 0;
    if (a > Q30) a = Q30;
    z = arc_angle(root_floor((Q30 - a) << 30), root_floor(a << 30));
    rad = (z * TO_RAD + (64'sd1 << 31)) >>> 32;
    d = (rad * 12742 + (64'sd1 << 15)) >>> 16;
    if (d > DMAX) d = DMAX;
    leg.km = d[22:0];
    leg.near = (d[22:0] < radius_km);
  endtask

  // send one point pair and queue its distance; valid drops only on idle
  task automatic send_pair(input longint la, oa, lb, ob);
    logic [103:0] pair;
    leg_t leg;
    pair = '0;
    pair[23:0] = la[23:0];
    pair[48:24] = oa[24:0];
    pair[72:49] = lb[23:0];
    pair[97:73] = ob[24:0];
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    haversine(pair, leg);
    legs_q.insert(legs_q.size(), leg);
    if (leg.near) near_hits++;
    s_axis_tdata <= pair;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pairs_sent++;
  endtask

  // sink ready: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // check every result transfer against the oldest expected distance
  always @(posedge clk_i) begin
    leg_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      legs_seen++;
      if (legs_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = legs_q.pop_front();
        if (got.km !== want.km || got.near !== want.near) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: dist exp %0d got %0d, within exp %0b got %0b",
                     want.km, got.km, want.near, got.near);
          end
        end
      end
    end
  end

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (legs_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_radius(input logic [22:0] r);
    drain();
    radius_km = r;
    cfg_wdata_i <= r;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint span_val(longint span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  // extremes, poles, antipodes, same point, out-of-range bit patterns
  task automatic test_directed();
    send_pair(0, 0, 0, 0);
    send_pair(LAT_SPAN, 0, -LAT_SPAN, 0);
    send_pair(0, 0, 0, LON_SPAN);
    send_pair(0, -LON_SPAN, 0, LON_SPAN);
    send_pair(LAT_SPAN, LON_SPAN, LAT_SPAN, -LON_SPAN);
    send_pair(-LAT_SPAN, -LON_SPAN, LAT_SPAN, LON_SPAN);
    send_pair(30 <<< 16, 45 <<< 16, -(30 <<< 16), -(135 <<< 16));
    send_pair(1, 1, 0, 0);
    send_pair(-1, -1, 0, 0);
    send_pair(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000);
    send_pair(24'hFFFFFF, 25'h1FFFFFF, 24'h7FFFFF, 25'h0FFFFFF);
    send_pair(24'h800000, 25'h1000000, 0, 0);
    send_pair(51 <<< 16, 0, 48 <<< 16, 2 <<< 16);
    send_pair(40 <<< 16, -(74 <<< 16), 34 <<< 16, -(118 <<< 16));
  endtask

  task automatic test_random(input int n, input bit wild);
    longint la, oa;
    for (int k = 0; k < n; k++) begin
      if (wild && $urandom_range(9) == 0) begin
        send_pair($urandom, $urandom, $urandom, $urandom);
      end else if ($urandom_range(3) == 0) begin
        // nearby points so that the range flag toggles
        la = span_val(LAT_SPAN);
        oa = span_val(LON_SPAN);
        send_pair(la, oa, la + span_val(1 << 18), oa + span_val(1 << 18));
      end else begin
        send_pair(span_val(LAT_SPAN), span_val(LON_SPAN),
                  span_val(LAT_SPAN), span_val(LON_SPAN));
      end
    end
  endtask

  // sink holds off for a long stretch while pairs keep coming
  task automatic test_backpressure();
    hold_cycles = 3 * LATENCY;
    test_random(2 * LATENCY, 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 35;
    sink_idle_pct = 70;
    test_random(450, 1'b1);
    set_radius(23'd5124000);
    test_random(150, 1'b1);
    set_radius(23'd256000);
    send_idle_pct = 70;
    sink_idle_pct = 35;
    test_random(450, 1'b1);
    set_radius(23'd1);
    test_random(50, 1'b0);
    set_radius(23'h7FFFFF);
    send_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();
    set_radius(23'd1000000);
    test_random(300, 1'b1);
    set_radius(23'd0);
    test_random(50, 1'b0);
    drain();
    $display("covered %0d point pairs, %0d distances checked, %0d inside radius",
             pairs_sent, legs_seen, near_hits);
    $display("radius settings 0 to full scale, random and long sink stalls");
    if (mismatches == 0 && legs_q.size() == 0) begin
      $display("great_circle_distance regression: pass");
    end else begin
      $display("great_circle_distance regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("great_circle_distance regression: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/gcd_pkg.sv
rtl/gcd_rot_cordic.sv
rtl/great_circle_distance.sv
test/great_circle_distance_tb.sv
